>>> design/bdgc_pkg.sv
package bdgc_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 16;
    localparam int GAIN_W    = 12;
    localparam int LIMIT_W   = 26;
    localparam int OUT_W     = 27;
    localparam int SUM_W     = 34;
    localparam int DIVD_W    = SUM_W + 1;
    localparam int MAG_W     = DIVD_W - 1;
    localparam int MEAN_W    = SAMPLE_W + 1;
    localparam int PROD_W    = MEAN_W + GAIN_W;
    localparam int DCNT_W    = $clog2(MAG_W + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = LIMIT_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

    // Register reset values
    localparam logic [LEN_W-1:0]   RST_DECIM_LEN = 16'd16;
    localparam logic [GAIN_W-1:0]  RST_GAIN      = 12'd0;
    localparam logic [LIMIT_W-1:0] RST_LIMIT     = 26'd32767;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CLAMP
    } t_state;

    // Request to the divider
    typedef struct packed {
        logic                     start;
        logic signed [DIVD_W-1:0] dividend;
        logic [LEN_W-1:0]         divisor;
    } t_div_req;

endpackage

>>> design/bdgc_div.sv
module bdgc_div
    import bdgc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_div_req                 i_req,
    output logic                     o_done,
    output logic signed [MEAN_W-1:0] o_quot
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic [MAG_W-1:0]  r_quo, n_quo;
    logic [LEN_W-1:0]  r_div, n_div;

    logic [DIVD_W-1:0] abs_full;
    logic [LEN_W:0]    rem_sh;
    logic              ge;
    logic [LEN_W:0]    rem_sub;
    logic [MAG_W-1:0]  quo_signed;

    // Take magnitude of dividend; sign is restored at the end
    assign abs_full = i_req.dividend[DIVD_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;

    // One restoring step: shift in next bit, subtract divisor if it fits
    assign rem_sh  = {r_rem, r_quo[MAG_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(MAG_W);
            n_neg  = i_req.dividend[DIVD_W-1];
            n_rem  = '0;
            n_quo  = abs_full[MAG_W-1:0];
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            n_quo = {r_quo[MAG_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    // Quotient truncated toward zero: negate magnitude for a negative dividend
    assign quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quot     = quo_signed[MEAN_W-1:0];
    assign o_done     = r_done;

endmodule

>>> design/boxcar_decimator_gain_clamp.sv
// Boxcar average decimator with optional gain and symmetric clamp.
//
// Input stream s_axis_*: one signed 16-bit left-channel sample per item.
// Output stream m_axis_*: one signed 27-bit result per completed window.
// Config port i_cfg_*: index 0 decimation length, 1 gain, 2 clamp limit;
// write only while the block is idle.
//
// A sample that does not complete the window is added to the running sum
// and the block stays ready. The sample that completes the window starts
// the restoring divider, which retires one quotient bit per cycle; the
// multiply state and then the clamp state follow. Input is not ready from
// the closing sample until the result is loaded into the output register,
// so a new window cannot start before the last one is done.
//
// Reset clears the running sum and count and loads the register defaults
// (length 16, gain 0, limit 32767). The result sits in an output register:
// while it waits, new samples are still taken; if a second result is ready
// before the first is taken, the sequencer holds it and stops input.
module boxcar_decimator_gain_clamp
    import bdgc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Sample input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] left_sample
    // Result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [26:0] mean_value, [31:27] zero
);

    // Configuration registers
    logic [LEN_W-1:0]          r_len;
    logic signed [GAIN_W-1:0]  r_gain;
    logic [LIMIT_W-1:0]        r_limit;

    // Sequencer and datapath registers
    t_state                    r_state, n_state;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [LEN_W-1:0]          r_cnt, n_cnt;
    logic signed [MEAN_W-1:0]  r_mean, n_mean;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic                      r_ovalid, n_ovalid;
    logic [OUT_W-1:0]          r_odata, n_odata;

    logic                      s_acc;
    logic signed [SUM_W-1:0]   sum_add;
    logic [LEN_W-1:0]          cnt_inc;
    logic [LEN_W-1:0]          need;
    logic                      win_done;
    t_div_req                  div_req;
    logic                      div_done;
    logic signed [MEAN_W-1:0]  div_quot;
    logic signed [PROD_W-1:0]  product;
    logic signed [PROD_W-1:0]  lim;
    logic signed [PROD_W-1:0]  neg_lim;
    logic [OUT_W-1:0]          result;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= RST_DECIM_LEN;
            r_gain  <= RST_GAIN;
            r_limit <= RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DECIM_LEN: r_len   <= i_cfg_data[LEN_W-1:0];
                CFG_GAIN:      r_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT:     r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Accumulate and check the window
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign sum_add  = r_sum + {{(SUM_W-SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}},
                               s_axis_tdata[SAMPLE_W-1:0]};
    assign cnt_inc  = r_cnt + 1'b1;
    assign need     = (r_len == '0) ? LEN_W'(1) : r_len;
    assign win_done = (cnt_inc >= need);

    // Divider request: rounded dividend sum + count/2 over count
    assign div_req.start    = s_acc && win_done;
    assign div_req.dividend = {sum_add[SUM_W-1], sum_add}
                            + {{(DIVD_W-LEN_W+1){1'b0}}, cnt_inc[LEN_W-1:1]};
    assign div_req.divisor  = cnt_inc;

    bdgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Gain and clamp
    assign product = r_mean * r_gain;
    assign lim     = (r_limit == '0) ? PROD_W'(1)
                                     : {{(PROD_W-LIMIT_W){1'b0}}, r_limit};
    assign neg_lim = -lim;

    always_comb begin
        if (r_gain == '0) begin
            result = {{(OUT_W-MEAN_W){r_mean[MEAN_W-1]}}, r_mean};
        end else if (r_prod > lim) begin
            result = lim[OUT_W-1:0];
        end else if (r_prod < neg_lim) begin
            result = neg_lim[OUT_W-1:0];
        end else begin
            result = r_prod[OUT_W-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_mean   = r_mean;
        n_prod   = r_prod;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        s_axis_tready = 1'b0;

        // Drop the output item once taken
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (win_done) begin
                        n_sum   = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end else begin
                        n_sum = sum_add;
                        n_cnt = cnt_inc;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_mean  = div_quot;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = product;
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                // Hold until the output register is free
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = result;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_mean  <= n_mean;
        r_prod  <= n_prod;
        r_odata <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r_odata};

    // Divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

    // A sample that does not close the window advances the count by one
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !win_done) |=> (r_cnt == $past(cnt_inc)))
        else $error("sample count did not advance");

    // A finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLAMP && m_axis_tvalid && !m_axis_tready)
        |=> (r_state == ST_CLAMP))
        else $error("result loaded over a waiting item");

    // Closing a window clears the running sum and count
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_sum == '0 && r_cnt == '0 && r_state == ST_DIV))
        else $error("window not cleared at close");

endmodule

>>> tb/sv/boxcar_mean_checker.sv
module boxcar_mean_checker
    import bdgc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,   // [15:0] left_sample
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,  // [26:0] mean_value, [31:27] zero
    output int                     o_fail_count,
    output int                     o_pending
);

    // Shadow copy of the block's registers and window state
    logic [LEN_W-1:0]   len_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [LIMIT_W-1:0] limit_reg;
    longint             window_sum;
    logic [LEN_W-1:0]   window_count;

    // Means still owed by the block, oldest first
    logic [OUT_W-1:0]   expected_means[$];

    // Add one sample to the window; close the window once the count reaches the length
    task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] sample);
        logic [LEN_W-1:0] need;
        longint           n;
        longint           mean;
        longint           scaled;
        longint           bound;
        need = (len_reg == '0) ? LEN_W'(1) : len_reg;
        window_sum   += longint'(sample);
        window_count += 1'b1;
        if (window_count == '0 || window_count < need) begin
            return;
        end
        // Rounded mean over the actual count, quotient truncated toward zero
        n            = longint'(window_count);
        mean         = (window_sum + n / 2) / n;
        window_sum   = 0;
        window_count = '0;
        scaled       = mean;
        // Apply gain and symmetric clamp unless the gain is zero
        if (gain_reg != '0) begin
            scaled = mean * longint'($signed(gain_reg));
            bound  = (limit_reg == '0) ? 1 : longint'(limit_reg);
            if (scaled > bound) begin
                scaled = bound;
            end
            if (scaled < -bound) begin
                scaled = -bound;
            end
        end
        expected_means.push_back(scaled[OUT_W-1:0]);
    endtask

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            len_reg      = RST_DECIM_LEN;
            gain_reg     = RST_GAIN;
            limit_reg    = RST_LIMIT;
            window_sum   = 0;
            window_count = '0;
            expected_means.delete();
        end else begin
            // Compare each taken result with the oldest expected mean
            if (i_out_tvalid && i_out_tready) begin
                if (expected_means.size() == 0) begin
                    $error("mean_value unexpected: expected none, got %0d",
                           $signed(i_out_tdata[OUT_W-1:0]));
                    o_fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (i_out_tdata[OUT_W-1:0] !== want) begin
                        $error("mean_value mismatch: expected %0d, got %0d",
                               $signed(want), $signed(i_out_tdata[OUT_W-1:0]));
                        o_fail_count++;
                    end
                end
            end
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DECIM_LEN: len_reg   = i_cfg_data[LEN_W-1:0];
                    CFG_GAIN:      gain_reg  = i_cfg_data[GAIN_W-1:0];
                    CFG_LIMIT:     limit_reg = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_tvalid && i_in_tready) begin
                accumulate_sample(i_in_tdata[SAMPLE_W-1:0]);
            end
        end
        o_pending = expected_means.size();
    end

endmodule

>>> tb/sv/boxcar_decimator_gain_clamp_test.sv
module boxcar_decimator_gain_clamp_test;
    import bdgc_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 65;
    localparam int PRESSURE_PHASE = 3;

    typedef enum int {
        RX_STREAM,
        RX_MOSTLY,
        RX_SPARSE
    } t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] left_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [26:0] mean_value, [31:27] zero

    int fail_count;
    int pending;
    int burst_left;
    bit gaps_on;
    bit hold_req;
    int idle_cycles;

    boxcar_decimator_gain_clamp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    boxcar_mean_checker mean_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: long hold-off on request, otherwise a changing stall pattern
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold_left;
        rx_mode       = RX_STREAM;
        mode_left     = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_STREAM: m_axis_tready <= 1'b1;
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) < 7);
                    default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one sample and hold it until taken; insert a gap at the end of a burst when gaps are on
    task automatic push_item(input logic [SAMPLE_W-1:0] sample);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 12);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop offering and wait for every owed mean; optionally let the block go quiet
    task automatic wait_drained(input bit settle);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end
    endtask

    // Write all three registers on consecutive cycles; unused upper data bits get noise
    task automatic set_config(input logic [LEN_W-1:0] len, input logic [GAIN_W-1:0] gain,
                              input logic [LIMIT_W-1:0] limit);
        logic [CFG_W-1:0] noise;
        noise = CFG_W'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DECIM_LEN;
        i_cfg_data <= {noise[CFG_W-1:LEN_W], len};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_GAIN;
        i_cfg_data <= {noise[CFG_W-1:GAIN_W], gain};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= limit;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            7, 8:    return LEN_W'($urandom_range(5, 20));
            9:       return LEN_W'($urandom_range(21, 60));
            default: return LEN_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 7))
            0, 1, 2: return '0;
            3:       return $urandom_range(0, 1) ? 12'h001 : 12'hFFF;
            4:       return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] random_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LIMIT_W'(1);
            2:       return LIMIT_W'($urandom_range(2, 1000));
            3:       return LIMIT_W'(32767);
            4:       return '1;
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [LEN_W-1:0] len;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_DECIM_LEN;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        idle_cycles   = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero length: every sample comes straight through, gain bypassed
        set_config(16'd0, 12'h000, 26'd0);
        push_item(16'h7FFF);
        push_item(16'h8000);
        push_item(16'h0000);
        push_item(16'hFFFF);
        push_item(16'h0001);
        wait_drained(1'b1);

        // Zero limit acts as one; most negative gain
        set_config(16'd1, 12'h800, 26'd0);
        push_item(16'h7FFF);
        push_item(16'h8000);
        push_item(16'h0000);
        push_item(16'h0005);
        wait_drained(1'b1);

        // Largest gain against the widest limit: no clamping
        set_config(16'd1, 12'h7FF, 26'h3FFFFFF);
        push_item(16'h7FFF);
        push_item(16'h8000);
        wait_drained(1'b1);

        // Rounding of half values in both directions
        set_config(16'd2, 12'h000, 26'd32767);
        push_item(16'h0001);
        push_item(16'h0000);
        push_item(16'hFFFF);
        push_item(16'h0000);
        push_item(16'hFFFD);
        push_item(16'h0000);
        push_item(16'h0003);
        push_item(16'h0000);
        wait_drained(1'b1);

        // Length lowered mid-window: next sample closes the window over the real count
        set_config(16'd16, 12'h003, 26'd100000);
        repeat (5) push_item(random_sample());
        wait_drained(1'b1);
        set_config(16'd3, 12'h003, 26'd100000);
        push_item(random_sample());
        wait_drained(1'b1);

        // Largest length at the most negative sample, then lowered to close the window
        gaps_on = 1'b0;
        set_config(16'hFFFF, 12'h000, 26'd32767);
        repeat (20) push_item(16'h8000);
        wait_drained(1'b1);
        set_config(16'd1, 12'h000, 26'd32767);
        push_item(16'h8000);
        wait_drained(1'b1);

        // Random phases; partial windows carry across each reconfiguration
        for (int p = 0; p < RAND_PHASES; p++) begin
            len = random_length();
            if (p == PRESSURE_PHASE) begin
                len = LEN_W'($urandom_range(0, 1));
            end
            set_config(len, random_gain(), random_limit());
            gaps_on = (p == PRESSURE_PHASE) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == PRESSURE_PHASE) begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                push_item(random_sample());
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained(1'b0);
                end
            end
            wait_drained(1'b1);
        end

        s_axis_tvalid <= 1'b0;
        wait_drained(1'b1);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/bdgc_pkg.sv
design/bdgc_div.sv
design/boxcar_decimator_gain_clamp.sv
tb/sv/boxcar_mean_checker.sv
tb/sv/boxcar_decimator_gain_clamp_test.sv
